// File: rtl/core/bcm_pkg.sv
`default_nettype none
package bcm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP,
    ST_FINISH,
    ST_LOOKUP,
    ST_EXEC,
    ST_OUT
  } state_t;

  // number of buffer entries; entry indexes travel as 6-bit fields
  localparam int NUM_BUFFERS = 64;

  // request kinds
  localparam logic [1:0] REQ_FETCH   = 2'd0;
  localparam logic [1:0] REQ_WRBACK  = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_DIRTY   = 2'd3;

  // result status
  localparam logic [2:0] STS_HIT   = 3'd0;
  localparam logic [2:0] STS_READ  = 3'd1;
  localparam logic [2:0] STS_NOBUF = 3'd2;
  localparam logic [2:0] STS_NONE  = 3'd3;
  localparam logic [2:0] STS_WROTE = 3'd4;
  localparam logic [2:0] STS_ERR   = 3'd5;

  // device commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [7:0] REF_MAX = 8'hFF;

endpackage
`default_nettype wire

// File: rtl/core/bcm_entry_ram.sv
`default_nettype none
module bcm_entry_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/block_buffer_cache_manager.sv
// channel | dir | tdata (low bit up)                          | tuser
// s_*     | in  | device_id 8, block_number 32, buffer_index 6 | req_type 2
// m_*     | out | entry_index 6, device_command 2,             | status 3
//         |     | command_device 8, command_sector 33, wake 1  |
//
// one request at a time; s_tready is high only while the sequencer idles
// a read scans the allocated entries, one per cycle through the entry ram,
// and sweeps them once more when an entry leaves the free order
// write back, release and mark dirty take one ram read and one ram write
// an index never allocated answers without touching the entry ram
// the result sits in an output register; a stalled m side holds the next result
// reset is synchronous; the entry ram needs no clearing, the fill count guards it
`default_nettype none
module block_buffer_cache_manager #(
  parameter int SECTORS_PER_BLOCK = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // device_id, block_number, buffer_index
  input  wire logic [1:0]  s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [55:0] m_tdata,   // entry_index, device_command, command_device,
                                      // command_sector, wake_waiter
  output logic      [2:0]  m_tuser    // status
);
  import bcm_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam int POS_W = IDX_W + 1;
  localparam int CMP_W = (POS_W > 6) ? POS_W : 6;
  localparam logic [POS_W-1:0] NOT_FREE = POS_W'(NUM_BUFFERS);

  // one ram word per buffer entry
  typedef struct packed {
    logic [7:0]       dev;
    logic [31:0]      blk;
    logic [7:0]       refc;
    logic             valid;
    logic             dirty;
    logic [POS_W-1:0] pos;    // place in free order, NOT_FREE when referenced
  } entry_t;

  state_t state, state_next;

  // captured request
  logic [1:0]       req;
  logic [7:0]       dev;
  logic [31:0]      blk;
  logic [5:0]       bidx;

  // bookkeeping
  logic [POS_W-1:0] alloc;       // entries ever allocated (fill count)
  logic [POS_W-1:0] free_cnt;    // members of the free order
  logic             waiter;

  // scan and sweep sequencer
  logic [POS_W-1:0] cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             hit_found, vic_found;
  logic [IDX_W-1:0] hit_idx, vic_idx;
  entry_t           hit_word;
  logic [IDX_W-1:0] e_idx;
  entry_t           e_word;
  logic [POS_W-1:0] rm_pos;

  // pending result
  logic [2:0]  res_status;
  logic [5:0]  res_ent;
  logic [1:0]  res_cmd;
  logic [7:0]  res_cdev;
  logic [32:0] res_csec;
  logic        res_wake;

  // ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  // decide / exec results
  entry_t           dec_word;
  logic [IDX_W-1:0] dec_idx;
  logic [POS_W-1:0] dec_pos;
  logic             dec_nobuf, dec_new;
  logic [2:0]       dec_status;
  logic [1:0]       dec_cmd;

  entry_t           ex_word;
  logic [2:0]       ex_status;
  logic [1:0]       ex_cmd;
  logic             ex_wake, ex_push;

  logic             idx_bad, scan_more, out_free;
  logic [32:0]      sector;

  bcm_entry_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_BUFFERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready  = (state == ST_IDLE);
  assign idx_bad   = CMP_W'(s_tdata[45:40]) >= CMP_W'(alloc);
  assign scan_more = cnt < alloc;
  assign out_free  = !m_tvalid || m_tready;

  // read request: choose entry after the scan
  always_comb begin
    dec_word   = hit_word;
    dec_idx    = hit_idx;
    dec_pos    = hit_word.pos;
    dec_nobuf  = 1'b0;
    dec_new    = 1'b0;
    dec_status = STS_NONE;
    dec_cmd    = CMD_NONE;
    if (hit_found) begin
      if (hit_word.valid) begin
        if (hit_word.refc == REF_MAX) begin
          dec_status = STS_ERR;
        end else begin
          dec_word.refc = hit_word.refc + 8'd1;
          dec_status    = STS_HIT;
        end
      end else begin
        dec_word.valid = 1'b1;
        dec_word.dirty = 1'b0;
        dec_status     = STS_READ;
        dec_cmd        = CMD_READ;
      end
    end else begin
      dec_word.dev   = dev;
      dec_word.blk   = blk;
      dec_word.refc  = 8'd1;
      dec_word.valid = 1'b1;
      dec_word.dirty = 1'b0;
      dec_status     = STS_READ;
      dec_cmd        = CMD_READ;
      if (alloc < NOT_FREE) begin
        dec_idx = alloc[IDX_W-1:0];
        dec_pos = NOT_FREE;
        dec_new = 1'b1;
      end else if (vic_found) begin
        dec_idx = vic_idx;
        dec_pos = '0;
      end else begin
        dec_nobuf = 1'b1;
      end
    end
    dec_word.pos = NOT_FREE;
  end

  // write back, release, mark dirty on the named entry
  always_comb begin
    ex_word   = ram_rdata;
    ex_status = STS_NONE;
    ex_cmd    = CMD_NONE;
    ex_wake   = 1'b0;
    ex_push   = 1'b0;
    case (req)
      REQ_WRBACK: begin
        if (ram_rdata.dirty) begin
          ex_word.dirty = 1'b0;
          ex_word.valid = 1'b1;
          ex_status     = STS_WROTE;
          ex_cmd        = CMD_WRITE;
        end
      end
      REQ_RELEASE: begin
        if (ram_rdata.refc == 8'd0) begin
          ex_status = STS_ERR;
        end else begin
          if (ram_rdata.dirty) begin
            ex_word.dirty = 1'b0;
            ex_word.valid = 1'b1;
            ex_status     = STS_WROTE;
            ex_cmd        = CMD_WRITE;
          end
          ex_word.refc = ram_rdata.refc - 8'd1;
          if (ram_rdata.refc == 8'd1) begin
            ex_wake = waiter;
            if (ram_rdata.pos >= NOT_FREE) begin
              ex_word.pos = free_cnt;
              ex_push     = 1'b1;
            end
          end
        end
      end
      REQ_DIRTY: begin
        if (ram_rdata.refc == 8'd0) begin
          ex_status = STS_ERR;
        end else begin
          ex_word.dirty = 1'b1;
        end
      end
      default: begin
        ex_status = STS_ERR;
      end
    endcase
  end

  assign sector = 33'({1'b0, (ex_cmd != CMD_NONE) ? ram_rdata.blk : dec_word.blk}
                  * 33'(SECTORS_PER_BLOCK));

  // next state and ram control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = e_idx;
    ram_wdata  = e_word;
    ram_raddr  = cnt[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_FETCH) begin
            state_next = ST_SCAN;
          end else if (idx_bad) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_more && !rd_pend) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (dec_nobuf) begin
          state_next = ST_OUT;
        end else if (dec_pos < NOT_FREE) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SWEEP: begin
        // close the gap left by the removed free-order member
        if (rd_pend && ram_rdata.pos < NOT_FREE && ram_rdata.pos > rm_pos) begin
          ram_we          = 1'b1;
          ram_waddr       = rd_idx;
          ram_wdata       = ram_rdata;
          ram_wdata.pos   = ram_rdata.pos - POS_W'(1);
        end
        if (!scan_more && !rd_pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ram_we     = 1'b1;
        state_next = ST_OUT;
      end
      ST_LOOKUP: begin
        ram_raddr  = IDX_W'(bidx);
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        ram_we     = 1'b1;
        ram_waddr  = IDX_W'(bidx);
        ram_wdata  = ex_word;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc    <= '0;
      free_cnt <= '0;
      waiter   <= 1'b0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= ((state == ST_SCAN) || (state == ST_SWEEP)) && scan_more;
      if (state == ST_DECIDE) begin
        if (dec_nobuf) begin
          waiter <= 1'b1;
        end else begin
          if (dec_new) begin
            alloc <= alloc + POS_W'(1);
          end
          if (dec_pos < NOT_FREE) begin
            free_cnt <= free_cnt - POS_W'(1);
          end
        end
      end
      if (state == ST_EXEC) begin
        if (ex_push) begin
          free_cnt <= free_cnt + POS_W'(1);
        end
        if (ex_wake) begin
          waiter <= 1'b0;
        end
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt[IDX_W-1:0];
    if ((state == ST_SCAN || state == ST_SWEEP) && scan_more) begin
      cnt <= cnt + POS_W'(1);
    end
    case (state)
      ST_IDLE: begin
        req       <= s_tuser;
        dev       <= s_tdata[7:0];
        blk       <= s_tdata[39:8];
        bidx      <= s_tdata[45:40];
        cnt       <= '0;
        hit_found <= 1'b0;
        vic_found <= 1'b0;
        res_status <= STS_ERR;
        res_ent    <= s_tdata[45:40];
        res_cmd    <= CMD_NONE;
        res_cdev   <= '0;
        res_csec   <= '0;
        res_wake   <= 1'b0;
      end
      ST_SCAN: begin
        if (rd_pend) begin
          if (!hit_found && ram_rdata.dev == dev && ram_rdata.blk == blk) begin
            hit_found <= 1'b1;
            hit_idx   <= rd_idx;
            hit_word  <= ram_rdata;
          end
          if (ram_rdata.pos == '0) begin
            vic_found <= 1'b1;
            vic_idx   <= rd_idx;
          end
        end
      end
      ST_DECIDE: begin
        cnt        <= '0;
        e_idx      <= dec_idx;
        e_word     <= dec_word;
        rm_pos     <= dec_pos;
        res_status <= dec_nobuf ? STS_NOBUF : dec_status;
        res_ent    <= dec_nobuf ? 6'd0 : 6'(dec_idx);
        res_cmd    <= dec_nobuf ? CMD_NONE : dec_cmd;
        res_cdev   <= (!dec_nobuf && dec_cmd != CMD_NONE) ? dec_word.dev : 8'd0;
        res_csec   <= (!dec_nobuf && dec_cmd != CMD_NONE) ? sector : 33'd0;
        res_wake   <= 1'b0;
      end
      ST_EXEC: begin
        res_status <= ex_status;
        res_cmd    <= ex_cmd;
        res_cdev   <= (ex_cmd != CMD_NONE) ? ram_rdata.dev : 8'd0;
        res_csec   <= (ex_cmd != CMD_NONE) ? sector : 33'd0;
        res_wake   <= ex_wake;
      end
      ST_OUT: begin
        if (out_free) begin
          m_tuser <= res_status;
          m_tdata <= {6'd0, res_wake, res_csec, res_cdev, res_cmd, res_ent};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    alloc <= NOT_FREE) else $error("fill count beyond entry count");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= alloc) else $error("free order larger than allocated entries");

  a_err_no_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STS_ERR |-> m_tdata[7:6] == CMD_NONE)
    else $error("command issued with error status");

  a_read_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:6] == CMD_READ |-> m_tuser == STS_READ)
    else $error("device read without read status");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer took a second request at once");
`endif

endmodule
`default_nettype wire

// File: dv/block_cache_checker.sv
`timescale 1ns / 1ps
module block_cache_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [55:0] m_tdata,
  input  wire logic [2:0]  m_tuser,
  output int               mismatches,
  output int               outstanding,
  output int               results_seen,
  output int               nobuf_seen,
  output int               wake_seen
);
  import bcm_pkg::*;

  localparam int NBUF = 64;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry;
    logic [1:0]  cmd;
    logic [7:0]  cdev;
    logic [32:0] csec;
    logic        wake;
  } cache_reply_t;

  // shadow of the cache state
  logic [7:0]  tag_dev [NBUF];
  logic [31:0] tag_blk [NBUF];
  logic [7:0]  refs [NBUF];
  logic        valid_q [NBUF];
  logic        dirty_q [NBUF];
  int          lru_pos [NBUF];   // NBUF means not on the free list
  int          used;
  logic        waiter;

  cache_reply_t awaited_replies [$];

  function automatic logic [32:0] first_sector(logic [31:0] blk);
    return {blk, 1'b0};
  endfunction

  task automatic lru_unlink(int e);
    int p;
    p = lru_pos[e];
    if (p >= NBUF) return;
    for (int i = 0; i < NBUF; i++)
      if (lru_pos[i] < NBUF && lru_pos[i] > p) lru_pos[i]--;
    lru_pos[e] = NBUF;
  endtask

  task automatic lru_append(int e);
    int n;
    n = 0;
    if (lru_pos[e] < NBUF) return;
    for (int i = 0; i < NBUF; i++)
      if (lru_pos[i] < NBUF) n++;
    lru_pos[e] = n;
  endtask

  // issue a device write for a dirty entry
  task automatic flush_entry(int e, inout cache_reply_t r);
    r.cmd    = CMD_WRITE;
    r.cdev   = tag_dev[e];
    r.csec   = first_sector(tag_blk[e]);
    r.status = STS_WROTE;
    dirty_q[e] = 1'b0;
    valid_q[e] = 1'b1;
  endtask

  task automatic predict_request(logic [1:0] req, logic [7:0] dev, logic [31:0] blk,
                                 logic [5:0] idx, output cache_reply_t r);
    int  e;
    logic hit;
    e   = NBUF;
    hit = 1'b0;
    r   = '0;
    r.status = STS_NONE;
    if (req == REQ_FETCH) begin
      for (int i = 0; i < used; i++) begin
        if (!hit && tag_dev[i] == dev && tag_blk[i] == blk) begin
          e = i;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (used < NBUF) begin
          e = used;
          used++;
        end else begin
          for (int i = 0; i < NBUF; i++)
            if (e == NBUF && lru_pos[i] == 0) e = i;
        end
        if (e >= NBUF) begin
          waiter   = 1'b1;
          r.status = STS_NOBUF;
        end else begin
          lru_unlink(e);
          valid_q[e] = 1'b0;
          dirty_q[e] = 1'b0;
          refs[e]    = 8'd1;
          tag_dev[e] = dev;
          tag_blk[e] = blk;
        end
      end else begin
        lru_unlink(e);
        if (valid_q[e]) begin
          if (refs[e] == REF_MAX) r.status = STS_ERR;
          else begin
            refs[e]++;
            r.status = STS_HIT;
          end
        end
      end
      if (e < NBUF) begin
        r.entry = e[5:0];
        if (!valid_q[e]) begin
          r.cmd      = CMD_READ;
          r.cdev     = tag_dev[e];
          r.csec     = first_sector(tag_blk[e]);
          r.status   = STS_READ;
          dirty_q[e] = 1'b0;
          valid_q[e] = 1'b1;
        end
      end
    end else begin
      r.entry = idx;
      if (int'(idx) >= used) r.status = STS_ERR;
      else if (req == REQ_WRBACK) begin
        if (dirty_q[idx]) flush_entry(idx, r);
      end else if (req == REQ_RELEASE) begin
        if (refs[idx] == 8'd0) r.status = STS_ERR;
        else begin
          if (dirty_q[idx]) flush_entry(idx, r);
          refs[idx]--;
          if (refs[idx] == 8'd0) begin
            lru_append(idx);
            if (waiter) begin
              r.wake = 1'b1;
              waiter = 1'b0;
            end
          end
        end
      end else begin
        if (refs[idx] == 8'd0) r.status = STS_ERR;
        else dirty_q[idx] = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cache_reply_t exp_r;
    cache_reply_t got_r;
    if (rst) begin
      for (int i = 0; i < NBUF; i++) begin
        refs[i] = 8'd0;
        valid_q[i] = 1'b0;
        dirty_q[i] = 1'b0;
        lru_pos[i] = NBUF;
        tag_dev[i] = 8'd0;
        tag_blk[i] = 32'd0;
      end
      used = 0;
      waiter = 1'b0;
      awaited_replies.delete();
      mismatches = 0;
      results_seen = 0;
      nobuf_seen = 0;
      wake_seen = 0;
    end else begin
      // a result is always for an earlier request, so pop before push
      if (m_tvalid && m_tready) begin
        results_seen++;
        got_r.status = m_tuser;
        got_r.entry  = m_tdata[5:0];
        got_r.cmd    = m_tdata[7:6];
        got_r.cdev   = m_tdata[15:8];
        got_r.csec   = m_tdata[48:16];
        got_r.wake   = m_tdata[49];
        if (got_r.status == STS_NOBUF) nobuf_seen++;
        if (got_r.wake) wake_seen++;
        if (awaited_replies.size() == 0)
          report_mismatch("unexpected result", {8'd0, m_tdata}, 64'd0);
        else begin
          exp_r = awaited_replies.pop_front();
          if (got_r.status !== exp_r.status) report_mismatch("status", got_r.status, exp_r.status);
          if (got_r.entry !== exp_r.entry) report_mismatch("entry_index", got_r.entry, exp_r.entry);
          if (got_r.cmd !== exp_r.cmd) report_mismatch("device_command", got_r.cmd, exp_r.cmd);
          if (got_r.cdev !== exp_r.cdev) report_mismatch("command_device", got_r.cdev, exp_r.cdev);
          if (got_r.csec !== exp_r.csec) report_mismatch("command_sector", got_r.csec, exp_r.csec);
          if (got_r.wake !== exp_r.wake) report_mismatch("wake_waiter", got_r.wake, exp_r.wake);
          if (m_tdata[55:50] !== 6'd0) report_mismatch("tdata padding", m_tdata[55:50], 0);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_request(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[45:40], exp_r);
        awaited_replies.push_back(exp_r);
      end
    end
    outstanding = awaited_replies.size();
  end

endmodule

// File: dv/tb_block_buffer_cache_manager.sv
`timescale 1ns / 1ps
module tb_block_buffer_cache_manager;
  import bcm_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // device_id, block_number, buffer_index
  logic [1:0]  s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // entry_index, device_command, command_device, command_sector, wake
  logic [2:0]  m_tuser;   // status

  int mismatches, outstanding, results_seen, nobuf_seen, wake_seen;
  int requests_sent;
  int idle_cycles;
  logic s_taken;
  logic hold_off_req;
  logic [7:0]  key_dev [96];
  logic [31:0] key_blk [96];

  // watchdog limit; the worst path is a full scan plus free-list unlink
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 400;

  block_buffer_cache_manager dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  block_cache_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen),
    .nobuf_seen(nobuf_seen), .wake_seen(wake_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // transfer flag sampled at the rising edge, read back at the falling edge
  always @(posedge clk) begin
    s_taken <= s_tvalid && s_tready;
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one, sometimes none at all
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, plus the long hold when asked for
  initial begin
    int stall;
    int hold;
    m_tready = 1'b0;
    stall = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  // one request transfer; valid stays high straight into the next item when no gap
  task automatic send_request(logic [1:0] req, logic [7:0] dev, logic [31:0] blk,
                              logic [5:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {2'b00, idx, blk, dev};
    do @(negedge clk); while (!s_taken);
    requests_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [5:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 6'($urandom);
    return 6'($urandom_range(0, 47));
  endfunction

  initial begin
    int k;
    int r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_FETCH;
    hold_off_req = 1'b0;
    requests_sent = 0;
    idle_cycles = 0;
    s_taken = 1'b0;
    for (int i = 0; i < 96; i++) begin
      key_dev[i] = 8'($urandom_range(0, 3));
      key_blk[i] = (i < 8) ? 32'($urandom) : 32'($urandom_range(0, 40));
    end
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, every request kind, the error cases
    send_request(REQ_FETCH, 8'h00, 32'h0000_0000, 6'd0);     // miss, first entry
    send_request(REQ_FETCH, 8'hFF, 32'hFFFF_FFFF, 6'd63);    // miss, sector needs all 33 bits
    send_request(REQ_FETCH, 8'hFF, 32'hFFFF_FFFF, 6'd0);     // hit, valid
    send_request(REQ_WRBACK, 8'h00, 32'h0, 6'd0);            // clean, nothing to do
    send_request(REQ_DIRTY, 8'h00, 32'h0, 6'd1);
    send_request(REQ_WRBACK, 8'h00, 32'h0, 6'd1);            // dirty, device write
    send_request(REQ_DIRTY, 8'h00, 32'h0, 6'd0);
    send_request(REQ_RELEASE, 8'h00, 32'h0, 6'd0);           // write back, count to zero
    send_request(REQ_RELEASE, 8'h00, 32'h0, 6'd0);           // zero count: error
    send_request(REQ_DIRTY, 8'h00, 32'h0, 6'd0);             // mark dirty on free entry: error
    send_request(REQ_WRBACK, 8'hAA, 32'h5555_5555, 6'd63);   // never allocated
    send_request(REQ_RELEASE, 8'h55, 32'hAAAA_AAAA, 6'd63);
    send_request(REQ_DIRTY, 8'h00, 32'h0, 6'd2);
    send_request(REQ_FETCH, 8'h00, 32'h0000_0000, 6'd0);     // hit on a free entry
    send_request(REQ_FETCH, 8'hAA, 32'h5555_5555, 6'd21);
    send_request(REQ_FETCH, 8'h55, 32'hAAAA_AAAA, 6'd42);
    send_request(REQ_RELEASE, 8'h00, 32'h0, 6'd1);
    send_request(REQ_RELEASE, 8'h00, 32'h0, 6'd1);           // plain release, no write
    send_request(REQ_FETCH, 8'h00, 32'h8000_0000, 6'd0);

    // reference count runs into its top on one entry
    for (int i = 0; i < 258; i++) send_request(REQ_FETCH, 8'h7E, 32'h1234_5678, 6'd0);

    // sender pauses until everything is back, then the receiver holds off
    drain_results();
    hold_off_req = 1'b1;

    // random mix over a small key pool so hits, reuse and the free list all get work
    for (int i = 0; i < 700; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        k = $urandom_range(0, 95);
        if ($urandom_range(0, 9) < 7) send_request(REQ_FETCH, key_dev[k], key_blk[k], pick_index());
        else send_request(REQ_FETCH, 8'($urandom), 32'($urandom), pick_index());
      end else if (r < 75) send_request(REQ_RELEASE, 8'($urandom), 32'($urandom), pick_index());
      else if (r < 88) send_request(REQ_DIRTY, 8'($urandom), 32'($urandom), pick_index());
      else send_request(REQ_WRBACK, 8'($urandom), 32'($urandom), pick_index());
    end

    // exhaust the cache with fresh blocks, then release every entry once to wake the waiter
    for (int i = 0; i < 90; i++) send_request(REQ_FETCH, 8'hC3, 32'($urandom), 6'($urandom));
    for (int i = 0; i < 64; i++) begin
      if ($urandom_range(0, 3) == 0) send_request(REQ_DIRTY, 8'h0, 32'h0, 6'(i));
      send_request(REQ_RELEASE, 8'h0, 32'h0, 6'(i));
    end
    for (int i = 0; i < 60; i++) begin
      k = $urandom_range(0, 95);
      send_request(($urandom_range(0, 1) == 0) ? REQ_FETCH : REQ_RELEASE,
                   key_dev[k], key_blk[k], 6'($urandom));
    end

    drain_results();
    repeat (150) @(negedge clk);
    $display("covered %0d requests, %0d results, %0d no-buffer answers, %0d waiter wakeups",
             requests_sent, results_seen, nobuf_seen, wake_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: block_buffer_cache_manager.f
rtl/core/bcm_pkg.sv
rtl/core/bcm_entry_ram.sv
rtl/core/block_buffer_cache_manager.sv
dv/block_cache_checker.sv
dv/tb_block_buffer_cache_manager.sv
